>>> hdl/hbfe_pkg.sv
`timescale 1ns / 1ps

package hbfe_pkg;

  // three spatial axes
  localparam int NUM_AXES = 3;

  // configuration port index width, leaves room for unused indexes
  localparam int CFG_IDX_W = 4;

  // width of the rounding threshold register
  localparam int THR_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING_CONST   = 4'd0,
    REG_REST_LENGTH    = 4'd1,
    REG_CUTOFF_LENGTH  = 4'd2,
    REG_TINY_THRESHOLD = 4'd3
  } cfg_reg_t;

endpackage

>>> hdl/hbfe_isqrt.sv
`timescale 1ns / 1ps

// dual-lane pipelined integer square root, one result bit per stage
module hbfe_isqrt #(
  parameter int RW = 33,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad_a,
  input  logic [2*RW-1:0] rad_b,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root_a,
  output logic [RW-1:0]   root_b,
  output logic [SW-1:0]   side_out
);

  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;

  logic [RW-1:0]   vld_r;
  logic [RW-1:0]   vld_p;
  logic [REMW-1:0] rem_r    [2][RW];
  logic [REMW-1:0] rem_p    [2][RW];
  logic [REMW-1:0] rem_nxt  [2][RW];
  logic [RW-1:0]   root_r   [2][RW];
  logic [RW-1:0]   root_p   [2][RW];
  logic [RW-1:0]   root_nxt [2][RW];
  logic [RADW-1:0] rad_r    [2][RW];
  logic [RADW-1:0] rad_p    [2][RW];
  logic [RADW-1:0] rad_nxt  [2][RW];
  logic [SW-1:0]   side_r   [RW];
  logic [SW-1:0]   side_p   [RW];

  assign vld_p = {vld_r[RW-2:0], in_valid};

  for (genvar s = 0; s < RW; s++) begin : g_prev
    if (s == 0) begin : g_first
      assign rem_p[0][s]  = '0;
      assign rem_p[1][s]  = '0;
      assign root_p[0][s] = '0;
      assign root_p[1][s] = '0;
      assign rad_p[0][s]  = rad_a;
      assign rad_p[1][s]  = rad_b;
      assign side_p[s]    = side_in;
    end else begin : g_rest
      assign rem_p[0][s]  = rem_r[0][s-1];
      assign rem_p[1][s]  = rem_r[1][s-1];
      assign root_p[0][s] = root_r[0][s-1];
      assign root_p[1][s] = root_r[1][s-1];
      assign rad_p[0][s]  = rad_r[0][s-1];
      assign rad_p[1][s]  = rad_r[1][s-1];
      assign side_p[s]    = side_r[s-1];
    end
  end

  // bring in two radicand bits, try root*4+1
  always_comb begin
    logic [REMW+1:0] t;
    logic [REMW+1:0] trial;
    for (int s = 0; s < RW; s++) begin
      for (int l = 0; l < 2; l++) begin
        t     = {rem_p[l][s], rad_p[l][s][RADW-1 -: 2]};
        trial = {2'b00, root_p[l][s], 2'b01};
        if (t >= trial) begin
          rem_nxt[l][s]  = REMW'(t - trial);
          root_nxt[l][s] = {root_p[l][s][RW-2:0], 1'b1};
        end else begin
          rem_nxt[l][s]  = REMW'(t);
          root_nxt[l][s] = {root_p[l][s][RW-2:0], 1'b0};
        end
        rad_nxt[l][s] = {rad_p[l][s][RADW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < RW; s++) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[l][s]  <= rem_nxt[l][s];
          root_r[l][s] <= root_nxt[l][s];
          rad_r[l][s]  <= rad_nxt[l][s];
        end
        side_r[s] <= side_p[s];
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root_a    = root_r[0][RW-1];
  assign root_b    = root_r[1][RW-1];
  assign side_out  = side_r[RW-1];

endmodule

>>> hdl/hbfe_div.sv
`timescale 1ns / 1ps

// three-lane pipelined restoring divider with a shared divisor
module hbfe_div
  import hbfe_pkg::*;
#(
  parameter int NW  = 97,
  parameter int DVW = 49,
  parameter int QW  = 32,
  parameter int SW  = 37
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NW-1:0]       num [NUM_AXES],
  input  logic [DVW-1:0]      divisor,
  input  logic [SW-1:0]       side_in,
  output logic                out_valid,
  output logic [QW-1:0]       quot [NUM_AXES],
  output logic [NUM_AXES-1:0] ovf,
  output logic [SW-1:0]       side_out
);

  localparam int WW = (NW > DVW + QW) ? NW : DVW + QW;

  logic [QW:0]           vld_r;
  logic [WW-1:0]         rem_r    [QW+1][NUM_AXES];
  logic [WW-1:0]         rem_nxt  [QW+1][NUM_AXES];
  logic [QW-1:0]         q_r      [QW+1][NUM_AXES];
  logic [QW-1:0]         q_nxt    [QW+1][NUM_AXES];
  logic [DVW-1:0]        dv_r     [QW+1];
  logic [NUM_AXES-1:0]   ovf_r    [QW+1];
  logic [NUM_AXES-1:0]   ovf_nxt  [QW+1];
  logic [SW-1:0]         side_r   [QW+1];

  always_comb begin
    logic [WW-1:0] sh;
    // entry stage: quotient overflow check
    for (int l = 0; l < NUM_AXES; l++) begin
      rem_nxt[0][l] = WW'(num[l]);
      q_nxt[0][l]   = '0;
      ovf_nxt[0][l] = WW'(num[l]) >= (WW'(divisor) << QW);
    end
    for (int j = 1; j <= QW; j++) begin
      sh         = WW'(dv_r[j-1]) << (QW - j);
      ovf_nxt[j] = ovf_r[j-1];
      for (int l = 0; l < NUM_AXES; l++) begin
        if (rem_r[j-1][l] >= sh) begin
          rem_nxt[j][l] = rem_r[j-1][l] - sh;
          q_nxt[j][l]   = {q_r[j-1][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[j][l] = rem_r[j-1][l];
          q_nxt[j][l]   = {q_r[j-1][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= divisor;
      side_r[0] <= side_in;
      for (int j = 1; j <= QW; j++) begin
        dv_r[j]   <= dv_r[j-1];
        side_r[j] <= side_r[j-1];
      end
      for (int j = 0; j <= QW; j++) begin
        ovf_r[j] <= ovf_nxt[j];
        for (int l = 0; l < NUM_AXES; l++) begin
          rem_r[j][l] <= rem_nxt[j][l];
          q_r[j][l]   <= q_nxt[j][l];
        end
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign ovf       = ovf_r[QW];
  assign side_out  = side_r[QW];
  for (genvar l = 0; l < NUM_AXES; l++) begin : g_quot
    assign quot[l] = q_r[QW][l];
  end

endmodule

>>> hdl/harmonic_bond_force_energy_core.sv
`timescale 1ns / 1ps

// harmonic spring bond: one bond displacement in, one force/energy item out
// in_*  : stream item, tdata = disp_x, disp_y, disp_z, rand_x, rand_y, rand_z
// out_* : stream item, tdata = force_x, force_y, force_z, bond_energy,
//         tuser = bond_broken (force and energy then read zero)
// cfg_* : register writes, index 0 spring constant, 1 rest length,
//         2 cutoff length (zero disables), 3 rounding threshold; other
//         indexes are ignored; write only while the pipeline is empty
// throughput: one item per clock while the output is not stalled, every stage takes a new item each cycle
// depth: set by the square root (one root bit per stage) and the force divider
//   (one quotient bit per stage), plus the field split, square, sum, stretch,
//   multiply, partial product, energy and output stages
// stall: the whole pipeline holds while a result waits in the output
//   register and out_tready is low; nothing is lost or repeated
// reset: clears all stage valid bits and loads the register defaults
//   (k = 1.0, r = 1.0, no cutoff, threshold one lsb)
module harmonic_bond_force_energy_core
  import hbfe_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // disp_x, disp_y, disp_z, rand_x, rand_y, rand_z from bit 0 up
  input  logic [((3*DATA_WIDTH+3*FRAC_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // force_x, force_y, force_z, bond_energy from bit 0 up
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]                 out_tdata,
  // bond_broken
  output logic                                              out_tuser,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]                              cfg_index,
  input  logic [DATA_WIDTH-1:0]                             cfg_data
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int RW     = DW + 1;          // root width
  localparam int SQW    = 2 * RW;          // sum of squares width
  localparam int MW     = DW + RW;         // k * stretch
  localparam int EW     = MW + RW;         // k * stretch^2
  localparam int NW     = MW + DW;         // force numerator
  localparam int DVW    = RW + FB;         // force divisor
  localparam int QW     = DW;              // quotient bits
  localparam int OUT_TW = ((4*DW+7)/8)*8;
  localparam int SIDE1W = 1 + 3 + 3*FB + 3 + 3*DW;
  localparam int SIDE2W = DW + 5;

  localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] POS_LIM = ~NEG_LIM;

  // configuration registers
  logic [DW-1:0]    k_r;
  logic [DW-1:0]    r_r;
  logic [DW-1:0]    cut_r;
  logic [THR_W-1:0] thr_r;

  logic adv;

  assign cfg_ready = 1'b1;
  // pipeline moves whenever the output register is free or being emptied
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= DW'(1) << FB;
      r_r   <= DW'(1) << FB;
      cut_r <= '0;
      thr_r <= THR_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPRING_CONST:   k_r   <= cfg_data;
        REG_REST_LENGTH:    r_r   <= cfg_data;
        REG_CUTOFF_LENGTH:  cut_r <= cfg_data;
        REG_TINY_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // stage 0: field split and magnitudes
  // ---------------------------------------------------------------
  logic [NUM_AXES-1:0][DW-1:0] dmag_c;
  logic [NUM_AXES-1:0]         dsgn_c;
  logic [NUM_AXES-1:0][FB-1:0] rmag_c;
  logic [NUM_AXES-1:0]         rsgn_c;

  always_comb begin
    logic [DW-1:0] d;
    logic [FB-1:0] rv;
    for (int a = 0; a < NUM_AXES; a++) begin
      d         = in_tdata[a*DW +: DW];
      rv        = in_tdata[3*DW + a*FB +: FB];
      dsgn_c[a] = d[DW-1];
      dmag_c[a] = d[DW-1] ? DW'(-d) : d;
      rsgn_c[a] = rv[FB-1];
      rmag_c[a] = rv[FB-1] ? FB'(-rv) : rv;
    end
  end

  logic                        v0_r;
  logic [NUM_AXES-1:0][DW-1:0] dmag0_r;
  logic [NUM_AXES-1:0]         dsgn0_r;
  logic [NUM_AXES-1:0][FB-1:0] rmag0_r;
  logic [NUM_AXES-1:0]         rsgn0_r;

  // stage 1: squares
  logic                          v1_r;
  logic [NUM_AXES-1:0][2*DW-1:0] dsq1_r;
  logic [NUM_AXES-1:0][2*FB-1:0] rsq1_r;
  logic [2*DW-1:0]               c2_1_r;
  logic [NUM_AXES-1:0][DW-1:0]   dmag1_r;
  logic [NUM_AXES-1:0]           dsgn1_r;
  logic [NUM_AXES-1:0][FB-1:0]   rmag1_r;
  logic [NUM_AXES-1:0]           rsgn1_r;

  // stage 2: sums and cutoff check
  logic                        v2_r;
  logic [SQW-1:0]              sum2_r;
  logic [SQW-1:0]              rsum2_r;
  logic                        brk2_r;
  logic [NUM_AXES-1:0][DW-1:0] dmag2_r;
  logic [NUM_AXES-1:0]         dsgn2_r;
  logic [NUM_AXES-1:0][FB-1:0] rmag2_r;
  logic [NUM_AXES-1:0]         rsgn2_r;

  logic [SQW-1:0] sum_c;
  logic [SQW-1:0] rsum_c;

  assign sum_c  = SQW'(dsq1_r[0]) + SQW'(dsq1_r[1]) + SQW'(dsq1_r[2]);
  assign rsum_c = SQW'(rsq1_r[0]) + SQW'(rsq1_r[1]) + SQW'(rsq1_r[2]);

  // square root outputs
  logic                        vq_c;
  logic [RW-1:0]               dist_c;
  logic [RW-1:0]               rroot_c;
  logic [SIDE1W-1:0]           sq_side_c;
  logic                        q_brk;
  logic [NUM_AXES-1:0]         q_rsgn;
  logic [NUM_AXES-1:0][FB-1:0] q_rmag;
  logic [NUM_AXES-1:0]         q_dsgn;
  logic [NUM_AXES-1:0][DW-1:0] q_dmag;

  assign {q_brk, q_rsgn, q_rmag, q_dsgn, q_dmag} = sq_side_c;

  // stage 3: stretch and direction choice
  logic                        v3_r;
  logic [RW-1:0]               drmag3_r;
  logic                        drneg3_r;
  logic [NUM_AXES-1:0][DW-1:0] vmag3_r;
  logic [NUM_AXES-1:0]         vneg3_r;
  logic [RW-1:0]               den3_r;
  logic                        nouse3_r;
  logic                        brk3_r;

  logic                        drneg_c;
  logic                        tinyd_c;

  assign drneg_c = dist_c < RW'(r_r);
  assign tinyd_c = dist_c <= RW'(thr_r);

  // stage 4: k * stretch
  logic                        v4_r;
  logic [MW-1:0]               m4_r;
  logic [RW-1:0]               drmag4_r;
  logic [NUM_AXES-1:0][DW-1:0] vmag4_r;
  logic [NUM_AXES-1:0]         neg4_r;
  logic [RW-1:0]               den4_r;
  logic                        nof4_r;
  logic                        brk4_r;

  // stage 5: partial products
  logic                           v5_r;
  logic [2*RW-1:0]                elo5_r;
  logic [DW+RW-1:0]               ehi5_r;
  logic [NUM_AXES-1:0][RW+DW-1:0] plo5_r;
  logic [NUM_AXES-1:0][2*DW-1:0]  phi5_r;
  logic [DVW-1:0]                 dv5_r;
  logic [NUM_AXES-1:0]            neg5_r;
  logic                           nof5_r;
  logic                           brk5_r;

  // stage 6: energy and numerators
  logic                v6_r;
  logic [NW-1:0]       num6_r [NUM_AXES];
  logic [DVW-1:0]      dv6_r;
  logic [DW-1:0]       eng6_r;
  logic [NUM_AXES-1:0] neg6_r;
  logic                nof6_r;
  logic                brk6_r;

  logic [EW-1:0] e_c;
  logic [EW-1:0] esh_c;

  assign e_c   = EW'(elo5_r) + (EW'(ehi5_r) << RW);
  assign esh_c = e_c >> (2*FB + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= vq_c;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0
      dmag0_r <= dmag_c;
      dsgn0_r <= dsgn_c;
      rmag0_r <= rmag_c;
      rsgn0_r <= rsgn_c;
      // stage 1
      for (int a = 0; a < NUM_AXES; a++) begin
        dsq1_r[a] <= (2*DW)'(dmag0_r[a]) * (2*DW)'(dmag0_r[a]);
        rsq1_r[a] <= (2*FB)'(rmag0_r[a]) * (2*FB)'(rmag0_r[a]);
      end
      c2_1_r  <= (2*DW)'(cut_r) * (2*DW)'(cut_r);
      dmag1_r <= dmag0_r;
      dsgn1_r <= dsgn0_r;
      rmag1_r <= rmag0_r;
      rsgn1_r <= rsgn0_r;
      // stage 2
      sum2_r  <= sum_c;
      rsum2_r <= rsum_c;
      brk2_r  <= (cut_r != '0) && (sum_c > SQW'(c2_1_r));
      dmag2_r <= dmag1_r;
      dsgn2_r <= dsgn1_r;
      rmag2_r <= rmag1_r;
      rsgn2_r <= rsgn1_r;
      // stage 3
      drneg3_r <= drneg_c;
      drmag3_r <= drneg_c ? RW'(r_r) - dist_c : dist_c - RW'(r_r);
      for (int a = 0; a < NUM_AXES; a++) begin
        vmag3_r[a] <= tinyd_c ? DW'(q_rmag[a]) : q_dmag[a];
        vneg3_r[a] <= tinyd_c ? q_rsgn[a] : q_dsgn[a];
      end
      den3_r   <= tinyd_c ? rroot_c : dist_c;
      nouse3_r <= tinyd_c && (rroot_c == '0);
      brk3_r   <= q_brk;
      // stage 4
      m4_r     <= MW'(k_r) * MW'(drmag3_r);
      drmag4_r <= drmag3_r;
      vmag4_r  <= vmag3_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        neg4_r[a] <= drneg3_r == vneg3_r[a];
      end
      den4_r <= den3_r;
      nof4_r <= (drmag3_r <= RW'(thr_r)) || nouse3_r || brk3_r;
      brk4_r <= brk3_r;
      // stage 5
      elo5_r <= (2*RW)'(m4_r[RW-1:0]) * (2*RW)'(drmag4_r);
      ehi5_r <= (DW+RW)'(m4_r[MW-1:RW]) * (DW+RW)'(drmag4_r);
      for (int a = 0; a < NUM_AXES; a++) begin
        plo5_r[a] <= (RW+DW)'(m4_r[RW-1:0]) * (RW+DW)'(vmag4_r[a]);
        phi5_r[a] <= (2*DW)'(m4_r[MW-1:RW]) * (2*DW)'(vmag4_r[a]);
      end
      dv5_r  <= {den4_r, {FB{1'b0}}};
      neg5_r <= neg4_r;
      nof5_r <= nof4_r;
      brk5_r <= brk4_r;
      // stage 6
      for (int a = 0; a < NUM_AXES; a++) begin
        num6_r[a] <= NW'(plo5_r[a]) + (NW'(phi5_r[a]) << RW);
      end
      dv6_r  <= dv5_r;
      eng6_r <= (esh_c > EW'({DW{1'b1}})) ? {DW{1'b1}} : esh_c[DW-1:0];
      neg6_r <= neg5_r;
      nof6_r <= nof5_r;
      brk6_r <= brk5_r;
    end
  end

  hbfe_isqrt #(
    .RW (RW),
    .SW (SIDE1W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .rad_a     (sum2_r),
    .rad_b     (rsum2_r),
    .side_in   ({brk2_r, rsgn2_r, rmag2_r, dsgn2_r, dmag2_r}),
    .out_valid (vq_c),
    .root_a    (dist_c),
    .root_b    (rroot_c),
    .side_out  (sq_side_c)
  );

  // force divider
  logic                vd_c;
  logic [QW-1:0]       quot_c [NUM_AXES];
  logic [NUM_AXES-1:0] ovf_c;
  logic [SIDE2W-1:0]   dv_side_c;
  logic [DW-1:0]       d_eng;
  logic                d_brk;
  logic                d_nof;
  logic [NUM_AXES-1:0] d_neg;

  assign {d_eng, d_brk, d_nof, d_neg} = dv_side_c;

  hbfe_div #(
    .NW  (NW),
    .DVW (DVW),
    .QW  (QW),
    .SW  (SIDE2W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v6_r),
    .num       (num6_r),
    .divisor   (dv6_r),
    .side_in   ({eng6_r, brk6_r, nof6_r, neg6_r}),
    .out_valid (vd_c),
    .quot      (quot_c),
    .ovf       (ovf_c),
    .side_out  (dv_side_c)
  );

  // saturation, sign and zeroing
  logic [NUM_AXES-1:0][DW-1:0] force_c;

  always_comb begin
    logic [DW-1:0] lim;
    logic [DW-1:0] fm;
    for (int a = 0; a < NUM_AXES; a++) begin
      lim = d_neg[a] ? NEG_LIM : POS_LIM;
      fm  = (ovf_c[a] || (quot_c[a] > lim)) ? lim : quot_c[a];
      if (d_nof || d_brk) begin
        force_c[a] = '0;
      end else begin
        force_c[a] = d_neg[a] ? DW'(-fm) : fm;
      end
    end
  end

  // output register
  logic                        out_valid_r;
  logic [NUM_AXES-1:0][DW-1:0] out_force_r;
  logic [DW-1:0]               out_eng_r;
  logic                        out_brk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_force_r <= force_c;
      out_eng_r   <= d_brk ? '0 : d_eng;
      out_brk_r   <= d_brk;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_eng_r, out_force_r});
  assign out_tuser  = out_brk_r;

`ifndef SYNTHESIS
  // a broken bond carries no force and no energy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("broken bond item with nonzero payload");

  // writes to unused indexes leave the registers alone
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index > REG_TINY_THRESHOLD)
    |=> $stable(k_r) && $stable(r_r) && $stable(cut_r) && $stable(thr_r))
    else $error("unused register index changed a register");

  // stage 0, 3 and 6 valid bits hold while the pipeline is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(v0_r) && $stable(v3_r) && $stable(v6_r))
    else $error("pipeline moved during a stall");

  // nothing leaves right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

>>> tb/harmonic_bond_force_energy_core_test.sv
`timescale 1ns / 1ps

module harmonic_bond_force_energy_core_test;
  import hbfe_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int IN_W = ((3*DW+3*FB+7)/8)*8;
  localparam int OUT_W = ((4*DW+7)/8)*8;
  // settle wait after a drain, LATENCY plus a margin
  localparam int LATENCY = 2*DW+9;
  localparam int SETTLE = LATENCY+20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int NUM_PHASES = 7;
  // an index the core must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  typedef struct packed {
    logic [DW-1:0] fx;
    logic [DW-1:0] fy;
    logic [DW-1:0] fz;
    logic [DW-1:0] energy;
    logic          broken;
  } bond_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DW-1:0]       val;
    logic [IN_W-1:0]     data;
    bit                  typed;
    bond_result_t        res;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  // local copy of the core's registers
  logic [DW-1:0] k_reg, r_reg, cut_reg;
  logic [THR_W-1:0] thr_reg;

  bond_result_t pending_results[$];
  script_row_t directed[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 20;
  bit hold_go = 0;
  int hold_left = 0;
  int stall_left = 0;

  harmonic_bond_force_energy_core #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root of a wide unsigned value
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] res, c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  function automatic logic [127:0] magn(input longint s);
    return (s < 0) ? 128'(-s) : 128'(s);
  endfunction

  // spring force and energy for one bond at the current register values
  function automatic bond_result_t bond_predict(input logic [IN_W-1:0] d);
    bond_result_t res;
    longint dx[3], rv[3], v[3];
    logic [127:0] sq, rsq, blen, drmag, e, den, m, q, lim, fm;
    bit drneg, vneg, neg;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      dx[i] = longint'($signed(d[DW*i +: DW]));
      rv[i] = longint'($signed(d[3*DW+FB*i +: FB]));
    end
    sq = '0;
    rsq = '0;
    for (int i = 0; i < 3; i++) begin
      sq += magn(dx[i]) * magn(dx[i]);
      rsq += magn(rv[i]) * magn(rv[i]);
    end
    // broken bond: cutoff enabled and exact distance beyond it
    if (cut_reg != 0 && sq > 128'(cut_reg) * 128'(cut_reg)) begin
      res.broken = 1'b1;
      return res;
    end
    blen = isqrt(sq);
    drneg = blen < 128'(r_reg);
    drmag = drneg ? 128'(r_reg) - blen : blen - 128'(r_reg);
    e = (128'(k_reg) * drmag * drmag) >> (2*FB+1);
    res.energy = (e > 128'({DW{1'b1}})) ? {DW{1'b1}} : e[DW-1:0];
    // tiny stretch: no force
    if (drmag <= 128'(thr_reg)) return res;
    if (blen > 128'(thr_reg)) begin
      v = dx;
      den = blen;
    end else begin
      // tiny distance: random offsets give the direction
      v = rv;
      den = isqrt(rsq);
      if (den == 0) return res;
    end
    m = 128'(k_reg) * drmag;
    den = den << FB;
    for (int i = 0; i < 3; i++) begin
      vneg = v[i] < 0;
      neg = (drneg == vneg);
      lim = neg ? (128'd1 << (DW-1)) : (128'd1 << (DW-1)) - 1;
      q = (m * magn(v[i])) / den;
      fm = (q > lim) ? lim : q;
      fm = neg ? -fm : fm;
      case (i)
        0: res.fx = fm[DW-1:0];
        1: res.fy = fm[DW-1:0];
        default: res.fz = fm[DW-1:0];
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_W-1:0] pack_item(input logic [DW-1:0] x, y, z,
                                                 input logic [FB-1:0] rx, ry, rz);
    return {rz, ry, rx, z, y, x};
  endfunction

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_go || hold_left > 0) begin
      if (hold_go) begin
        hold_go = 0;
        hold_left = 300;
      end
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) stall_left = gap_len();
    end
  end

  // result checker, each accepted item against the oldest expectation
  always @(posedge clk) begin
    bond_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[0 +: DW], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0 +: DW] !== want.fx) report_mismatch("force_x", out_tdata[0 +: DW], want.fx);
        if (out_tdata[DW +: DW] !== want.fy)
          report_mismatch("force_y", out_tdata[DW +: DW], want.fy);
        if (out_tdata[2*DW +: DW] !== want.fz)
          report_mismatch("force_z", out_tdata[2*DW +: DW], want.fz);
        if (out_tdata[3*DW +: DW] !== want.energy)
          report_mismatch("bond_energy", out_tdata[3*DW +: DW], want.energy);
        if (out_tuser !== want.broken)
          report_mismatch("bond_broken", DW'(out_tuser), DW'(want.broken));
      end
    end
  end

  // offer one item, expectation pushed when the core takes it
  task automatic send_item(input logic [IN_W-1:0] data, input bit typed,
                           input bond_result_t typed_res);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(typed ? typed_res : bond_predict(data));
    @(negedge clk);
  endtask

  // wait until every expected item is back and the pipeline has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPRING_CONST:   k_reg = val;
      REG_REST_LENGTH:    r_reg = val;
      REG_CUTOFF_LENGTH:  cut_reg = val;
      REG_TINY_THRESHOLD: thr_reg = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_item(input logic [DW-1:0] x, y, z, input logic [FB-1:0] rx, ry, rz,
                          input bit typed, input logic [DW-1:0] fx, fy, fz, e,
                          input logic b);
    script_row_t row;
    row = '{ROW_ITEM, '0, '0, pack_item(x, y, z, rx, ry, rz), typed, '{fx, fy, fz, e, b}};
    directed.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    script_row_t row;
    row = '{ROW_CFG, idx, val, '0, 1'b0, '0};
    directed.push_back(row);
  endtask

  // random displacement component of a chosen flavour
  function automatic logic [DW-1:0] rand_comp(input int flavour);
    case (flavour)
      0: return DW'($signed($urandom_range(0, 2**19)) - 2**18);
      1: return DW'($signed($urandom_range(0, 4)) - 2);
      2: return $urandom();
      default: return DW'($signed($urandom_range(0, 2**23)) - 2**22);
    endcase
  endfunction

  task automatic random_item();
    int flavour;
    logic [FB-1:0] rx, ry, rz;
    logic [DW-1:0] x;
    flavour = $urandom_range(0, 9);
    if (flavour < 5) flavour = 0;
    else if (flavour < 7) flavour = 1;
    else if (flavour < 9) flavour = 2;
    else flavour = 3;
    rx = $urandom();
    ry = $urandom();
    rz = $urandom();
    if ($urandom_range(0, 15) == 0) {rx, ry, rz} = '0;
    x = rand_comp(flavour);
    // now and then a stretch right at the rest length, or on the cutoff
    if ($urandom_range(0, 9) == 0) x = r_reg + DW'($signed($urandom_range(0, 40)) - 20);
    if ($urandom_range(0, 19) == 0 && cut_reg != 0)
      x = cut_reg + DW'($signed($urandom_range(0, 2)) - 1);
    send_item(pack_item(x, rand_comp(flavour), rand_comp(flavour), rx, ry, rz), 1'b0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    k_reg = 32'h0001_0000;
    r_reg = 32'h0001_0000;
    cut_reg = '0;
    thr_reg = 16'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows at reset values: zero bond, rest length, unit stretch
    add_item(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'h8000, 0);
    add_item(32'h1_0000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_item(32'h2_0000, 0, 0, 0, 0, 0, 1, -32'sh1_0000, 0, 0, 32'h8000, 0);
    add_item(0, -32'sh2_0000, 0, 0, 0, 0, 1, 0, 32'h1_0000, 0, 32'h8000, 0);
    // tiny distance with extreme random offsets
    add_item(1, 0, 0, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0);
    add_item(0, -1, 1, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
    // displacement extremes, force and energy saturate
    add_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'hffff, 16'hffff,
             0, 0, 0, 0, 0, 0);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // tiny stretch, one lsb past rest
    add_item(32'h1_0001, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_cfg(REG_CUTOFF_LENGTH, 32'h2_0000);
    add_item(32'h2_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(32'h2_0001, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    // unused index leaves every register alone
    add_cfg(REG_UNUSED, 32'h0);
    add_item(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'h8000, 0);
    add_item(32'h4_0000, 32'h3_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_item(directed[i].data, directed[i].typed, directed[i].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_SPRING_CONST, 32'hffff_ffff);
          write_reg(REG_REST_LENGTH, 32'h0);
          write_reg(REG_CUTOFF_LENGTH, 32'h0);
          write_reg(REG_TINY_THRESHOLD, 32'h0);
        end
        1: begin
          write_reg(REG_SPRING_CONST, 32'h0);
          write_reg(REG_REST_LENGTH, 32'hffff_ffff);
          write_reg(REG_CUTOFF_LENGTH, 32'hffff_ffff);
          write_reg(REG_TINY_THRESHOLD, 32'hffff);
        end
        2: begin
          write_reg(REG_SPRING_CONST, 32'h1_0000);
          write_reg(REG_REST_LENGTH, 32'h2_0000);
          write_reg(REG_CUTOFF_LENGTH, 32'h3_0000);
          write_reg(REG_TINY_THRESHOLD, 32'h10);
        end
        default: begin
          write_reg(REG_SPRING_CONST, $urandom_range(0, 3) == 0 ? $urandom() :
                                      $urandom_range(0, 32'h40_0000));
          write_reg(REG_REST_LENGTH, $urandom_range(0, 32'h4_0000));
          write_reg(REG_CUTOFF_LENGTH, $urandom_range(0, 2) == 0 ? 0 :
                                       $urandom_range(32'h1_0000, 32'h8_0000));
          write_reg(REG_TINY_THRESHOLD, $urandom_range(0, 3) == 0 ? $urandom() :
                                        $urandom_range(0, 64));
        end
      endcase
      // one phase runs flat out, the others idle at varying rates
      idle_pct = (ph == 3) ? 0 : $urandom_range(10, 50);
      for (int n = 0; n < RANDOM_ITEMS/NUM_PHASES; n++) begin
        // long receiver hold-off so the pipeline fills and stalls its input
        if (ph == 2 && n == 40) hold_go = 1;
        // sender waits for every result once
        if (ph == 4 && n == 60) drain();
        random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/hbfe_pkg.sv
hdl/hbfe_isqrt.sv
hdl/hbfe_div.sv
hdl/harmonic_bond_force_energy_core.sv
tb/harmonic_bond_force_energy_core_test.sv
